// ===== rtl/sensor_scan_average_scale_defines.svh =====
// Assertion macros shared by the sensor scan block.
`ifndef SENSOR_SCAN_AVERAGE_SCALE_DEFINES_SVH
`define SENSOR_SCAN_AVERAGE_SCALE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define SSAS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sensor_scan_average_scale: implication check failed");

// Next-cycle implication, switched off while reset is high.
`define SSAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sensor_scan_average_scale: next-cycle check failed");

`endif

// ===== rtl/ssas_pkg.sv =====
// Shared constants and types of the sensor scan, average and scale block.
`default_nettype none

package ssas_pkg;

  localparam int DEF_SAMPLES_PER_AVERAGE = 10;
  localparam int DEF_ADC_CHANNELS        = 4;
  localparam int DEF_MUX_STATES          = 4;
  localparam int DEF_SAMPLE_BITS         = 10;

  localparam int GAIN_W      = 20;
  localparam int OFFSET_W    = 28;
  localparam int CFG_DATA_W  = 28;
  localparam int CFG_INDEX_W = 2;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 2;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd77858;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 28'd43129242;
  localparam logic [BYTE_W-1:0]   FRAME_MARKER = 8'd255;
  localparam logic [BYTE_W-1:0]   MAX_DATA     = 8'd254;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCALE_GAIN   = 2'd0,
    REG_SCALE_OFFSET = 2'd1
  } cfg_reg_t;

  // Position of a completed average and the scan position that follows it.
  typedef struct packed {
    logic [POS_W-1:0] src_mux;
    logic [POS_W-1:0] src_channel;
    logic [POS_W-1:0] next_mux;
    logic [POS_W-1:0] next_channel;
    logic             frame_done;
  } pos_tag_t;

endpackage

`default_nettype wire

// ===== rtl/ssas_front.sv =====
// Front part: accumulates samples per scan position and steps the scan.
`default_nettype none

module ssas_front #(
  parameter int SAMPLES_PER_AVERAGE = 10,
  parameter int ADC_CHANNELS        = 4,
  parameter int MUX_STATES          = 4,
  parameter int SAMPLE_BITS         = 10,
  parameter int SUM_W               = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   queue_full,
  output logic                   push,
  output logic [SUM_W-1:0]       push_sum,
  output ssas_pkg::pos_tag_t     push_tag
);
  import ssas_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam int CH_W  = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;
  localparam int MUX_W = (MUX_STATES > 1) ? $clog2(MUX_STATES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);
  localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(ADC_CHANNELS - 1);
  localparam logic [MUX_W-1:0] MUX_LAST = MUX_W'(MUX_STATES - 1);

  logic [SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0] sample_count;
  logic [CH_W-1:0]  channel_index;
  logic [MUX_W-1:0] mux_index;

  logic             accept;
  logic             last_sample;
  logic             ch_wrap;
  logic             mux_wrap;
  logic [SUM_W-1:0] sum_with;
  logic [CH_W-1:0]  channel_index_next;
  logic [MUX_W-1:0] mux_index_next;

  assign in_stall    = queue_full;
  assign accept      = in_valid && !queue_full;
  assign sum_with    = sample_sum + SUM_W'(sample);
  assign last_sample = (sample_count == CNT_LAST);
  assign ch_wrap     = (channel_index == CH_LAST);
  assign mux_wrap    = (mux_index == MUX_LAST);

  always_comb begin
    channel_index_next = ch_wrap ? '0 : CH_W'(channel_index + 1'b1);
    mux_index_next     = mux_index;
    if (ch_wrap) begin
      mux_index_next = mux_wrap ? '0 : MUX_W'(mux_index + 1'b1);
    end
  end

  assign push                  = accept && last_sample;
  assign push_sum              = sum_with;
  assign push_tag.src_mux      = POS_W'(mux_index);
  assign push_tag.src_channel  = POS_W'(channel_index);
  assign push_tag.next_mux     = POS_W'(mux_index_next);
  assign push_tag.next_channel = POS_W'(channel_index_next);
  assign push_tag.frame_done   = ch_wrap && mux_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      sample_count  <= '0;
      channel_index <= '0;
      mux_index     <= '0;
    end else if (accept) begin
      if (last_sample) begin
        sample_sum    <= '0;
        sample_count  <= '0;
        channel_index <= channel_index_next;
        mux_index     <= mux_index_next;
      end else begin
        sample_sum   <= sum_with;
        sample_count <= CNT_W'(sample_count + 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ssas_queue.sv =====
// Short request queue between the front and back parts.
`default_nettype none

module ssas_queue #(
  parameter int DATA_W = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              empty,
  output logic              full
);
  import ssas_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [DATA_W-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign empty     = (fill == '0);
  assign full      = (fill == CNT_FULL);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   fill <= CNT_W'(fill + 1'b1);
        2'b01:   fill <= CNT_W'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ssas_back.sv =====
// Back part: divides, scales, clamps and emits results and frame markers.
`default_nettype none

module ssas_back #(
  parameter int SAMPLES_PER_AVERAGE = 10,
  parameter int SAMPLE_BITS         = 10,
  parameter int SUM_W               = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            queue_empty,
  input  logic [SUM_W-1:0]                head_sum,
  input  ssas_pkg::pos_tag_t              head_tag,
  output logic                            pop,
  input  logic [ssas_pkg::GAIN_W-1:0]     scale_gain,
  input  logic [ssas_pkg::OFFSET_W-1:0]   scale_offset,
  output logic [ssas_pkg::BYTE_W-1:0]     data_byte,
  output logic                            frame_end,
  output logic [ssas_pkg::POS_W-1:0]      source_mux,
  output logic [ssas_pkg::POS_W-1:0]      source_channel,
  output logic [ssas_pkg::POS_W-1:0]      next_mux,
  output logic [ssas_pkg::POS_W-1:0]      next_channel,
  output logic                            out_valid,
  input  logic                            out_stall
);
  import ssas_pkg::*;

  // Division by the sample count is a multiply by a rounded-up reciprocal;
  // with this shift the quotient is exact for every possible sum.
  localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int RECIP_W   = SUM_W + 2;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
  localparam int QPROD_W   = SUM_W + RECIP_W;
  localparam int AVG_W     = SAMPLE_BITS;
  localparam int PROD_W    = AVG_W + GAIN_W;
  localparam int DIFF_W    = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 1;
  localparam int SHIFT_W   = DIFF_W - 1 - FRAC_BITS;

  logic               s1_valid;
  logic [AVG_W-1:0]   s1_avg;
  pos_tag_t           s1_tag;
  logic               s2_valid;
  logic [PROD_W-1:0]  s2_prod;
  pos_tag_t           s2_tag;
  logic               marker_pending;

  logic               out_take;
  logic               out_free;
  logic               s2_free;
  logic               s1_move;
  logic               s1_free;
  logic [QPROD_W-1:0] quot_prod;
  logic [DIFF_W-1:0]  diff;
  logic [SHIFT_W-1:0] shifted;
  logic [BYTE_W-1:0]  scaled_byte;

  // An output holding a data result with a marker behind it is not free.
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || (out_take && !marker_pending);
  assign s2_free  = !s2_valid || out_free;
  assign s1_move  = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s2_free;
  assign pop      = !queue_empty && s1_free;

  assign quot_prod = QPROD_W'(head_sum) * QPROD_W'(RECIP);

  always_comb begin
    diff    = DIFF_W'(s2_prod) - DIFF_W'(scale_offset);
    shifted = diff[DIFF_W-2:FRAC_BITS];
    if (diff[DIFF_W-1]) begin
      scaled_byte = '0;
    end else if (shifted > SHIFT_W'(MAX_DATA)) begin
      scaled_byte = MAX_DATA;
    end else begin
      scaled_byte = BYTE_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      out_valid      <= 1'b0;
      marker_pending <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_take && marker_pending) begin
        marker_pending <= 1'b0;
      end else if (s2_valid && out_free) begin
        out_valid      <= 1'b1;
        marker_pending <= s2_tag.frame_done;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_avg <= quot_prod[DIV_SHIFT +: AVG_W];
      s1_tag <= head_tag;
    end
    if (s1_move) begin
      s2_prod <= PROD_W'(s1_avg) * PROD_W'(scale_gain);
      s2_tag  <= s1_tag;
    end
    if (out_take && marker_pending) begin
      data_byte      <= FRAME_MARKER;
      frame_end      <= 1'b1;
      source_mux     <= '0;
      source_channel <= '0;
    end else if (s2_valid && out_free) begin
      data_byte      <= scaled_byte;
      frame_end      <= 1'b0;
      source_mux     <= s2_tag.src_mux;
      source_channel <= s2_tag.src_channel;
      next_mux       <= s2_tag.next_mux;
      next_channel   <= s2_tag.next_channel;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sensor_scan_average_scale.sv =====
// Sensor scan block: samples in, averaged and scaled bytes out.
// The input channel takes one converter sample per request (sample, in_valid,
// in_stall) for the scan position that is current: channel fastest, then mux
// state. Every SAMPLES_PER_AVERAGE samples close a position; its average is
// scaled by scale_gain and scale_offset and sent on the output channel with
// its source and next positions. After the last position of a frame a second
// request follows: the marker byte 255 with frame_end high.
// One sample is accepted per cycle while in_stall is low. A closing sum passes
// s1 (reciprocal multiply), s2 (gain multiply) and the output (offset subtract
// and clamp); a frame marker follows in the cycle after its data result is
// taken. Closed positions wait in a four-entry queue; in_stall is high only
// while it is full, so an output stall reaches the input only after seven
// positions are held up: four queued and three in the pipeline. The user
// writes configuration (cfg_write_en, cfg_index, cfg_data) only while the
// block is idle, unenforced by the block. Reset clears the scan position, the
// running sum and all pending requests, and loads the default gain and offset.
`default_nettype none

`include "sensor_scan_average_scale_defines.svh"

module sensor_scan_average_scale #(
  parameter int SAMPLES_PER_AVERAGE = ssas_pkg::DEF_SAMPLES_PER_AVERAGE,
  parameter int ADC_CHANNELS        = ssas_pkg::DEF_ADC_CHANNELS,
  parameter int MUX_STATES          = ssas_pkg::DEF_MUX_STATES,
  parameter int SAMPLE_BITS         = ssas_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [ssas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssas_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic [ssas_pkg::BYTE_W-1:0]      data_byte,
  output logic                             frame_end,
  output logic [ssas_pkg::POS_W-1:0]       source_mux,
  output logic [ssas_pkg::POS_W-1:0]       source_channel,
  output logic [ssas_pkg::POS_W-1:0]       next_mux,
  output logic [ssas_pkg::POS_W-1:0]       next_channel,
  output logic                             out_valid,
  input  logic                             out_stall
);
  import ssas_pkg::*;

  localparam int SUM_W   = $clog2(SAMPLES_PER_AVERAGE * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int ENTRY_W = SUM_W + $bits(pos_tag_t);

  logic [GAIN_W-1:0]   scale_gain;
  logic [OFFSET_W-1:0] scale_offset;

  logic                queue_full;
  logic                queue_empty;
  logic                push;
  logic                pop;
  logic [SUM_W-1:0]    push_sum;
  pos_tag_t            push_tag;
  logic [ENTRY_W-1:0]  head_data;
  logic [SUM_W-1:0]    head_sum;
  pos_tag_t            head_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_gain   <= GAIN_RESET;
      scale_offset <= OFFSET_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_SCALE_GAIN:   scale_gain   <= cfg_data[GAIN_W-1:0];
        REG_SCALE_OFFSET: scale_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  ssas_front #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .ADC_CHANNELS        (ADC_CHANNELS),
    .MUX_STATES          (MUX_STATES),
    .SAMPLE_BITS         (SAMPLE_BITS),
    .SUM_W               (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .queue_full (queue_full),
    .push       (push),
    .push_sum   (push_sum),
    .push_tag   (push_tag)
  );

  ssas_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_tag}),
    .pop       (pop),
    .head_data (head_data),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  assign head_sum = head_data[ENTRY_W-1 -: SUM_W];
  assign head_tag = head_data[$bits(pos_tag_t)-1:0];

  ssas_back #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .SAMPLE_BITS         (SAMPLE_BITS),
    .SUM_W               (SUM_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (queue_empty),
    .head_sum       (head_sum),
    .head_tag       (head_tag),
    .pop            (pop),
    .scale_gain     (scale_gain),
    .scale_offset   (scale_offset),
    .data_byte      (data_byte),
    .frame_end      (frame_end),
    .source_mux     (source_mux),
    .source_channel (source_channel),
    .next_mux       (next_mux),
    .next_channel   (next_channel),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

  // The marker byte belongs to the frame end request alone.
  `SSAS_ASSERT_IMPLY(a_marker_byte, clk, rst, out_valid && frame_end, data_byte == FRAME_MARKER)
  `SSAS_ASSERT_IMPLY(a_data_not_marker, clk, rst, out_valid && !frame_end, data_byte != FRAME_MARKER)
  `SSAS_ASSERT_IMPLY(a_marker_source, clk, rst, out_valid && frame_end, source_mux == '0 && source_channel == '0)
  // A marker is always preceded by a data request, never by another marker.
  `SSAS_ASSERT_NEXT(a_single_marker, clk, rst, out_valid && !out_stall && frame_end, !(out_valid && frame_end))

endmodule

`default_nettype wire

// ===== dv/sensor_scan_average_scale_test.sv =====
// Self-checking testbench for the sensor scan, average and scale block.
`timescale 1ns / 1ps

module sensor_scan_average_scale_test;
  import ssas_pkg::*;

  localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_SAMPLES = 230;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_CAP    = 40;

  // Indexes that name no register; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_B = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    logic [POS_W-1:0]  src_mux;
    logic [POS_W-1:0]  src_channel;
    logic [POS_W-1:0]  nxt_mux;
    logic [POS_W-1:0]  nxt_channel;
  } scan_result_t;

  // One closed position: the first sample, the nine that follow it, and a
  // byte written out where it is obvious under the reset gain and offset.
  typedef struct packed {
    logic [SAMPLE_W-1:0] lead;
    logic [SAMPLE_W-1:0] rest;
    logic                has_byte;
    logic [BYTE_W-1:0]   want;
  } position_row_t;

  localparam position_row_t POSITION_ROWS [0:7] = '{
    '{10'd1023, 10'd1023, 1'b1, 8'd254},
    '{10'd0,    10'd0,    1'b1, 8'd0},
    '{10'd1,    10'd1,    1'b1, 8'd0},
    '{10'd9,    10'd0,    1'b1, 8'd0},
    '{10'd554,  10'd554,  1'b0, 8'd0},
    '{10'd600,  10'd600,  1'b0, 8'd0},
    '{10'd1023, 10'd0,    1'b0, 8'd0},
    '{10'd300,  10'd900,  1'b0, 8'd0}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic [SAMPLE_W-1:0]    sample = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      data_byte;
  logic                   frame_end;
  logic [POS_W-1:0]       source_mux;
  logic [POS_W-1:0]       source_channel;
  logic [POS_W-1:0]       next_mux;
  logic [POS_W-1:0]       next_channel;
  logic                   out_valid;
  logic                   out_stall = 1'b0;

  // Shadow of the block: register values and the running position.
  logic [GAIN_W-1:0]   gain_setting = GAIN_RESET;
  logic [OFFSET_W-1:0] offset_setting = OFFSET_RESET;
  logic [13:0]         position_sum = '0;
  int                  position_count = 0;
  int                  scan_mux = 0;
  int                  scan_channel = 0;

  scan_result_t awaited_results [$];
  int           typed_bytes [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int samples_taken = 0;
  int values_seen = 0;
  int markers_seen = 0;
  int cycle_count = 0;

  sensor_scan_average_scale i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .frame_end      (frame_end),
    .source_mux     (source_mux),
    .source_channel (source_channel),
    .next_mux       (next_mux),
    .next_channel   (next_channel),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] scale_average(input logic [SAMPLE_W-1:0] avg);
    logic [63:0] product;
    logic [63:0] shifted;
    product = 64'(avg) * 64'(gain_setting);
    if (product < 64'(offset_setting)) return '0;
    shifted = (product - 64'(offset_setting)) >> FRAC_BITS;
    if (shifted > 64'(MAX_DATA)) return MAX_DATA;
    return shifted[BYTE_W-1:0];
  endfunction

  // Adds one sample to the current position and queues the results it closes.
  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] value);
    scan_result_t res;
    int           typed;
    bit           frame_wrap;
    frame_wrap = 1'b0;
    position_sum = position_sum + 14'(value);
    position_count++;
    if (position_count < DEF_SAMPLES_PER_AVERAGE) return;
    res.data_byte = scale_average(SAMPLE_W'(position_sum / DEF_SAMPLES_PER_AVERAGE));
    if (typed_bytes.size() != 0) begin
      typed = typed_bytes.pop_front();
      if (typed >= 0) res.data_byte = BYTE_W'(typed);
    end
    res.frame_end   = 1'b0;
    res.src_mux     = POS_W'(scan_mux);
    res.src_channel = POS_W'(scan_channel);
    position_sum    = '0;
    position_count  = 0;
    if (scan_channel == DEF_ADC_CHANNELS - 1) begin
      scan_channel = 0;
      if (scan_mux == DEF_MUX_STATES - 1) begin
        scan_mux   = 0;
        frame_wrap = 1'b1;
      end else begin
        scan_mux++;
      end
    end else begin
      scan_channel++;
    end
    res.nxt_mux     = POS_W'(scan_mux);
    res.nxt_channel = POS_W'(scan_channel);
    awaited_results.push_back(res);
    if (frame_wrap) begin
      res.data_byte   = FRAME_MARKER;
      res.frame_end   = 1'b1;
      res.src_mux     = '0;
      res.src_channel = '0;
      awaited_results.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        accumulate_sample(sample);
        samples_taken++;
      end
      if (out_valid && !out_stall) begin
        got = '{data_byte, frame_end, source_mux, source_channel, next_mux, next_channel};
        if (got.frame_end) markers_seen++;
        else values_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, got byte=%0d end=%0d src=%0d/%0d next=%0d/%0d",
                     $time, got.data_byte, got.frame_end, got.src_mux, got.src_channel,
                     got.nxt_mux, got.nxt_channel);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
              $display("%0t: expected byte=%0d end=%0d src=%0d/%0d next=%0d/%0d, got byte=%0d end=%0d src=%0d/%0d next=%0d/%0d",
                       $time, want.data_byte, want.frame_end, want.src_mux, want.src_channel,
                       want.nxt_mux, want.nxt_channel, got.data_byte, got.frame_end,
                       got.src_mux, got.src_channel, got.nxt_mux, got.nxt_channel);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still awaited", $time, awaited_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ((send_gap_pct != 0) && ($urandom_range(99) < send_gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // The write enable drops for a cycle between writes.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_SCALE_GAIN) gain_setting = value[GAIN_W-1:0];
    else if (idx == REG_SCALE_OFFSET) offset_setting = value[OFFSET_W-1:0];
    @(posedge clk);
  endtask

  // Holds off the sender until every awaited result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  n;
    int                  phase;
    int                  mode;
    int                  base;
    int                  v;
    logic [GAIN_W-1:0]   g;
    logic [OFFSET_W-1:0] o;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_gap_pct   = 33;
    recv_stall_pct = 65;
    write_reg(CFG_INDEX_SPARE_A, '1);
    write_reg(CFG_INDEX_SPARE_B, CFG_DATA_W'($urandom));

    foreach (POSITION_ROWS[r]) begin
      typed_bytes.push_back(POSITION_ROWS[r].has_byte ? int'(POSITION_ROWS[r].want) : -1);
      for (n = 0; n < DEF_SAMPLES_PER_AVERAGE; n++)
        send_sample(n == 0 ? POSITION_ROWS[r].lead : POSITION_ROWS[r].rest);
    end

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      if (phase < 2) begin
        send_gap_pct   = 33;
        recv_stall_pct = 65;
      end else if (phase < 4) begin
        send_gap_pct   = 65;
        recv_stall_pct = 33;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      case (phase)
        0: begin
          g = GAIN_W'($urandom_range(40000, 8000));
          o = OFFSET_W'($urandom_range(int'(g) * 400, 0));
        end
        1: begin
          g = '1;
          o = '0;
        end
        2: begin
          g = '0;
          o = '1;
        end
        3: begin
          g = '1;
          o = '1;
        end
        4: begin
          g = GAIN_W'($urandom_range(70000, 0));
          o = OFFSET_W'($urandom_range(int'(g) * 1023, 0));
        end
        default: begin
          g = GAIN_RESET;
          o = OFFSET_RESET;
        end
      endcase
      // The upper data bits on a gain write lie outside the register.
      if (phase == 1) write_reg(REG_SCALE_GAIN, '1);
      else write_reg(REG_SCALE_GAIN, {(CFG_DATA_W - GAIN_W)'($urandom), g});
      write_reg(REG_SCALE_OFFSET, o);
      write_reg(phase[0] ? CFG_INDEX_SPARE_A : CFG_INDEX_SPARE_B, CFG_DATA_W'($urandom));

      for (n = 0; n < PHASE_SAMPLES; n++) begin
        if (n % DEF_SAMPLES_PER_AVERAGE == 0) begin
          mode = $urandom_range(5);
          base = $urandom_range(SAMPLE_MAX);
        end
        case (mode)
          0: v = 0;
          1: v = SAMPLE_MAX;
          2, 3: begin
            v = base + int'($urandom_range(16)) - 8;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          end
          default: v = $urandom_range(SAMPLE_MAX);
        endcase
        send_sample(SAMPLE_W'(v));
      end
    end

    drain_results();
    $display("Took %0d samples and checked %0d scaled values and %0d frame markers", samples_taken,
             values_seen, markers_seen);
    $display("over %0d gain and offset settings, with stalls on either side and none.",
             PHASE_COUNT + 1);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ssas_pkg.sv
rtl/ssas_front.sv
rtl/ssas_queue.sv
rtl/ssas_back.sv
rtl/sensor_scan_average_scale.sv
dv/sensor_scan_average_scale_test.sv
